@@ hdl/gbts_pkg.sv @@
// Shared types and constants for the gap buffer text store.
package gbts_pkg;

	localparam int CAPACITY_DEF = 4096;
	localparam int CHAR_W       = 8;
	localparam int IDX_W        = 12;
	localparam int RES_W        = 13;

	localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;

	// operation class, decided by the front end
	typedef enum logic [2:0] {
		K_INSERT,
		K_DEL_BACK,
		K_DEL_FWD,
		K_LEFT,
		K_RIGHT,
		K_READ,
		K_POSITION,
		K_NONE
	} op_kind_t;

	typedef struct packed {
		op_kind_t          kind;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic              ok;
		logic [CHAR_W-1:0] char_out;
		logic [RES_W-1:0]  cursor;
		logic [RES_W-1:0]  text_size;
		logic [RES_W-1:0]  row;
		logic [RES_W-1:0]  column;
		logic [RES_W-1:0]  line_total;
		logic              modified;
	} result_t;

endpackage

@@ hdl/gbts_front.sv @@
// Front end: accepts words, classifies the opcode and queues commands.
module gbts_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    opcode,
	input  logic [gbts_pkg::CHAR_W-1:0]   char_in,
	input  logic [gbts_pkg::IDX_W-1:0]    read_index,
	output logic                          q_valid,
	output gbts_pkg::cmd_t                q_cmd,
	input  logic                          q_pop
);
	import gbts_pkg::*;

	localparam logic [2:0] OPC_INSERT   = 3'd0;
	localparam logic [2:0] OPC_DEL_BACK = 3'd1;
	localparam logic [2:0] OPC_DEL_FWD  = 3'd2;
	localparam logic [2:0] OPC_LEFT     = 3'd3;
	localparam logic [2:0] OPC_RIGHT    = 3'd4;
	localparam logic [2:0] OPC_READ     = 3'd5;
	localparam logic [2:0] OPC_POSITION = 3'd6;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	op_kind_t   kind;
	logic       push;
	logic       pop;

	always_comb begin
		unique case (opcode)
			OPC_INSERT:   kind = K_INSERT;
			OPC_DEL_BACK: kind = K_DEL_BACK;
			OPC_DEL_FWD:  kind = K_DEL_FWD;
			OPC_LEFT:     kind = K_LEFT;
			OPC_RIGHT:    kind = K_RIGHT;
			OPC_READ:     kind = K_READ;
			OPC_POSITION: kind = K_POSITION;
			default:      kind = K_NONE;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_cmd    = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{kind: kind, ch: char_in, idx: read_index};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

@@ hdl/gbts_back.sv @@
// Back end: gap pointers, text memory, position walk and result register.
module gbts_back #(
	parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  gbts_pkg::cmd_t     q_cmd,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output gbts_pkg::result_t  res
);
	import gbts_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 2);
	localparam int IW = (PW > IDX_W) ? PW : IDX_W;
	localparam logic [PW-1:0] CAP = PW'(CAPACITY);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_FINISH = 2'd1;
	localparam logic [1:0] ST_WALK   = 2'd2;

	logic [CHAR_W-1:0] text_store [CAPACITY];
	logic [CHAR_W-1:0] rd_data_q;

	logic [1:0]        state_q, state_n;
	logic [PW-1:0]     gf_q, gp_q, gf_n, gp_n;
	logic              mod_q, mod_n;
	op_kind_t          kind_q;
	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	result_t           res_q;

	logic [PW-1:0]     walk_q, walk_nxt;
	logic              walk_vld_s1, walk_before_s1;
	logic [CW-1:0]     row_q, col_q, lines_q;
	logic              walk_start, walk_issue, walk_done;

	logic              re, we;
	logic [AW-1:0]     ra, wa;
	logic [CHAR_W-1:0] wd;
	logic              slot_free, res_load, ok_n, pos_n;
	logic [CHAR_W-1:0] cout_n;

	logic [IDX_W-1:0]  idx_sel;
	logic [PW-1:0]     gap_len, size_cur, size_n, phys;
	logic              read_ok;

	assign slot_free = !out_valid_q || out_ready;

	// read address and bound check for the read command
	assign idx_sel  = (state_q == ST_IDLE) ? q_cmd.idx : idx_q;
	assign gap_len  = gp_q - gf_q;
	assign size_cur = CAP - gap_len;
	assign read_ok  = IW'(idx_sel) < IW'(size_cur);
	assign phys     = (IW'(idx_sel) < IW'(gf_q)) ? PW'(idx_sel) : PW'(idx_sel) + gap_len;

	// walk skips the gap; start jumps it at once if the cursor is at zero
	assign walk_nxt   = walk_q + 1'b1;
	assign walk_issue = (state_q == ST_WALK) && (walk_q != CAP);
	assign walk_done  = (walk_q == CAP) && !walk_vld_s1;

	always_comb begin
		state_n    = state_q;
		q_pop      = 1'b0;
		re         = 1'b0;
		ra         = '0;
		we         = 1'b0;
		wa         = '0;
		wd         = rd_data_q;
		gf_n       = gf_q;
		gp_n       = gp_q;
		mod_n      = mod_q;
		res_load   = 1'b0;
		ok_n       = 1'b0;
		cout_n     = '0;
		pos_n      = 1'b0;
		walk_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.kind)
						K_INSERT: begin
							if (slot_free) begin
								q_pop    = 1'b1;
								res_load = 1'b1;
								if (gf_q < gp_q) begin
									we    = 1'b1;
									wa    = AW'(gf_q);
									wd    = q_cmd.ch;
									gf_n  = gf_q + 1'b1;
									mod_n = 1'b1;
									ok_n  = 1'b1;
								end
							end
						end
						K_DEL_BACK: begin
							if (slot_free) begin
								q_pop    = 1'b1;
								res_load = 1'b1;
								if (gf_q != '0) begin
									gf_n  = gf_q - 1'b1;
									mod_n = 1'b1;
									ok_n  = 1'b1;
								end
							end
						end
						K_DEL_FWD: begin
							if (slot_free) begin
								q_pop    = 1'b1;
								res_load = 1'b1;
								if (gp_q != CAP) begin
									gp_n  = gp_q + 1'b1;
									mod_n = 1'b1;
									ok_n  = 1'b1;
								end
							end
						end
						K_LEFT: begin
							q_pop   = 1'b1;
							re      = 1'b1;
							ra      = AW'(gf_q - 1'b1);
							state_n = ST_FINISH;
						end
						K_RIGHT: begin
							q_pop   = 1'b1;
							re      = 1'b1;
							ra      = AW'(gp_q);
							state_n = ST_FINISH;
						end
						K_READ: begin
							q_pop   = 1'b1;
							re      = 1'b1;
							ra      = AW'(phys);
							state_n = ST_FINISH;
						end
						K_POSITION: begin
							q_pop      = 1'b1;
							walk_start = 1'b1;
							state_n    = ST_WALK;
						end
						K_NONE: begin
							if (slot_free) begin
								q_pop    = 1'b1;
								res_load = 1'b1;
							end
						end
					endcase
				end
			end
			ST_FINISH: begin
				// read data held in rd_data_q until the result slot frees
				if (slot_free) begin
					res_load = 1'b1;
					state_n  = ST_IDLE;
					unique case (kind_q)
						K_LEFT: begin
							if (gf_q != '0) begin
								we   = 1'b1;
								wa   = AW'(gp_q - 1'b1);
								gf_n = gf_q - 1'b1;
								gp_n = gp_q - 1'b1;
								ok_n = 1'b1;
							end
						end
						K_RIGHT: begin
							if (gp_q != CAP) begin
								we   = 1'b1;
								wa   = AW'(gf_q);
								gf_n = gf_q + 1'b1;
								gp_n = gp_q + 1'b1;
								ok_n = 1'b1;
							end
						end
						K_READ: begin
							ok_n   = read_ok;
							cout_n = read_ok ? rd_data_q : '0;
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				re = walk_issue;
				ra = AW'(walk_q);
				if (walk_done && slot_free) begin
					res_load = 1'b1;
					ok_n     = 1'b1;
					pos_n    = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign size_n = CAP - (gp_n - gf_n);

	always_ff @(posedge clk) begin
		if (we) text_store[wa] <= wd;
		if (re) rd_data_q <= text_store[ra];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_cmd.kind;
			idx_q  <= q_cmd.idx;
		end
		if (res_load) begin
			res_q.ok         <= ok_n;
			res_q.char_out   <= cout_n;
			res_q.cursor     <= RES_W'(gf_n);
			res_q.text_size  <= RES_W'(size_n);
			res_q.row        <= pos_n ? RES_W'(row_q) : '0;
			res_q.column     <= pos_n ? RES_W'(col_q) : '0;
			res_q.line_total <= pos_n ? RES_W'(lines_q) : '0;
			res_q.modified   <= mod_n;
		end
	end

	// position walk counters, one character per cycle
	always_ff @(posedge clk) begin
		if (walk_start) begin
			walk_q  <= (gf_q == '0) ? gp_q : '0;
			row_q   <= CW'(1);
			col_q   <= '0;
			lines_q <= CW'(1);
		end else begin
			if (walk_issue) begin
				walk_q         <= (walk_nxt == gf_q) ? gp_q : walk_nxt;
				walk_before_s1 <= walk_q < gf_q;
			end
			if (walk_vld_s1) begin
				if (rd_data_q == NEWLINE) begin
					lines_q <= lines_q + 1'b1;
					if (walk_before_s1) begin
						row_q <= row_q + 1'b1;
						col_q <= '0;
					end
				end else if (walk_before_s1) begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gf_q        <= '0;
			gp_q        <= CAP;
			mod_q       <= 1'b0;
			out_valid_q <= 1'b0;
			walk_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_n;
			gf_q        <= gf_n;
			gp_q        <= gp_n;
			mod_q       <= mod_n;
			walk_vld_s1 <= walk_issue;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

@@ hdl/gap_buffer_text_store_unit.sv @@
// Gap buffer text store: top level with front queue and execution back end.
//
//   channel  | handshake           | word
//   ---------+---------------------+-------------------------------------------
//   input    | in_valid / in_ready | opcode, char_in, read_index
//   result   | out_valid/out_ready | ok, char_out, cursor, text_size, row,
//            |                     | column, line_total, modified
//
// Flow: a word is registered in the two-entry front queue. In the back end,
// insert, both deletes and the unused opcode load the result when taken;
// moves and read wait on the registered read port of the text memory;
// position walks the text one character a cycle through that same port,
// then drains the last read.
// Reset: arst_n clears the gap to the whole store, cursor 0, not modified.
// The text memory is not cleared; the gap pointers keep unwritten entries
// out of reach.
// Stalls: a result waits in the output register; the queue keeps taking
// words until both entries are full, then in_ready drops.
module gap_buffer_text_store_unit #(
	parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    opcode,
	input  logic [gbts_pkg::CHAR_W-1:0]   char_in,
	input  logic [gbts_pkg::IDX_W-1:0]    read_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [gbts_pkg::CHAR_W-1:0]   char_out,
	output logic [gbts_pkg::RES_W-1:0]    cursor,
	output logic [gbts_pkg::RES_W-1:0]    text_size,
	output logic [gbts_pkg::RES_W-1:0]    row,
	output logic [gbts_pkg::RES_W-1:0]    column,
	output logic [gbts_pkg::RES_W-1:0]    line_total,
	output logic                          modified
);
	import gbts_pkg::*;

	logic    q_valid;
	logic    q_pop;
	cmd_t    q_cmd;
	result_t res;

	// front: accept and classify, buffer up to two commands
	gbts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.char_in    (char_in),
		.read_index (read_index),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop)
	);

	// back: gap pointers, text memory, newline walk, result register
	gbts_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign ok         = res.ok;
	assign char_out   = res.char_out;
	assign cursor     = res.cursor;
	assign text_size  = res.text_size;
	assign row        = res.row;
	assign column     = res.column;
	assign line_total = res.line_total;
	assign modified   = res.modified;

	// a failed word carries no read byte and no position figures
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> (char_out == '0) && (row == '0) && (line_total == '0))
		else $error("failed result carries data");

	// position figures hang together
	a_pos_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (row != '0) |->
			ok && (row <= line_total) && ((CAPACITY >= 8192) || (column <= cursor)))
		else $error("position result inconsistent");

	// cursor never passes the end of the text
	a_cursor_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (CAPACITY < 8192) |-> (cursor <= text_size))
		else $error("cursor beyond text size");

endmodule
